FILE: hdl/lzrd_pkg.sv
package lzrd_pkg;

    // Command kinds carried in the header mode field
    localparam logic [2:0] KIND_LITERAL  = 3'd0;
    localparam logic [2:0] KIND_FILL     = 3'd1;
    localparam logic [2:0] KIND_FILL2    = 3'd2;
    localparam logic [2:0] KIND_SEQ      = 3'd3;
    localparam logic [2:0] KIND_COPY     = 3'd4;
    localparam logic [2:0] KIND_COPY_REV = 3'd5;
    localparam logic [2:0] KIND_COPY_BWD = 3'd6;
    localparam logic [2:0] KIND_EXT      = 3'd7;

    localparam logic [7:0] END_HEADER = 8'hFF;

    // Error codes reported on a status-only result
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BUSY      = 2'd1;
    localparam logic [1:0] ERR_IDLE_PULL = 2'd2;

    // One decoded beat handed from the parser to the history stage
    typedef struct packed {
        logic        has_result;
        logic        is_data;
        logic        finished;
        logic [31:0] total;
        logic [1:0]  err;
        logic [7:0]  direct;
        logic        use_mem;
        logic        rev;
    } lzrd_issue_t;

    function automatic logic [7:0] bit_reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = v[7 - k];
        end
        return r;
    endfunction

endpackage

FILE: hdl/lzrd_ram.sv
module lzrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/lzrd_parser.sv
module lzrd_parser
    import lzrd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 65536,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          mode,
    input  logic [7:0]    in_byte,
    input  logic          last_byte,
    output lzrd_issue_t   iss,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_EXTLEN  = 3'd1;
    localparam logic [2:0] PH_OFS_HI  = 3'd2;
    localparam logic [2:0] PH_OFS_LO  = 3'd3;
    localparam logic [2:0] PH_PARAM1  = 3'd4;
    localparam logic [2:0] PH_PARAM2  = 3'd5;
    localparam logic [2:0] PH_LITERAL = 3'd6;
    localparam logic [2:0] PH_RUN     = 3'd7;

    localparam logic [21:0] DEPTH_W  = 22'(HISTORY_DEPTH);
    localparam logic [16:0] DEPTH_17 = 17'(HISTORY_DEPTH);
    localparam logic [AW-1:0] WPOS_LAST = AW'(HISTORY_DEPTH - 1);

    logic [2:0]    phase_reg, phase_next;
    logic [2:0]    kind_reg, kind_next;
    logic [10:0]   rlen_reg, rlen_next;
    logic [10:0]   ridx_reg, ridx_next;
    logic [15:0]   org_reg, org_next;
    logic [7:0]    f1_reg, f1_next;
    logic [7:0]    f2_reg, f2_next;
    logic [AW-1:0] wpos_reg, wpos_next;
    logic [31:0]   count_reg, count_next;
    logic          ending_reg, ending_next;

    logic [11:0]   idx_inc;
    logic [11:0]   run_total;
    logic [16:0]   fwd_sum;
    logic [16:0]   bwd_diff;
    logic          rec;

    // Reduce a 16-bit offset modulo the history depth (quotient below 64)
    function automatic logic [15:0] mod_depth(input logic [15:0] v);
        logic [21:0] r;
        r = 22'(v);
        for (int k = 5; k >= 0; k--)
        begin
            if (r >= (DEPTH_W << k))
            begin
                r = r - (DEPTH_W << k);
            end
        end
        return r[15:0];
    endfunction

    function automatic logic [2:0] body_phase(input logic [2:0] kind);
        logic [2:0] p;
        if (kind == KIND_LITERAL)
        begin
            p = PH_LITERAL;
        end
        else if (kind <= KIND_SEQ)
        begin
            p = PH_PARAM1;
        end
        else
        begin
            p = PH_OFS_HI;
        end
        return p;
    endfunction

    // History read address for the current copy byte
    always_comb
    begin
        fwd_sum  = 17'(org_reg) + 17'(ridx_reg);
        if (fwd_sum >= DEPTH_17)
        begin
            fwd_sum = fwd_sum - DEPTH_17;
        end
        bwd_diff = 17'(org_reg) - 17'(ridx_reg);
        if (bwd_diff[16])
        begin
            bwd_diff = bwd_diff + DEPTH_17;
        end
        rd_addr = (kind_reg == KIND_COPY_BWD) ? bwd_diff[AW-1:0] : fwd_sum[AW-1:0];
        rd_en   = accept && mode && (phase_reg == PH_RUN)
                  && (kind_reg == KIND_COPY || kind_reg == KIND_COPY_REV
                      || kind_reg == KIND_COPY_BWD);
    end

    // Decode one beat: next parse state and the issued result
    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        rlen_next   = rlen_reg;
        ridx_next   = ridx_reg;
        org_next    = org_reg;
        f1_next     = f1_reg;
        f2_next     = f2_reg;
        wpos_next   = wpos_reg;
        count_next  = count_reg;
        ending_next = ending_reg;
        iss         = '0;
        rec         = 1'b0;

        idx_inc   = 12'(ridx_reg) + 12'd1;
        run_total = (kind_reg == KIND_FILL2) ? {rlen_reg, 1'b0} : {1'b0, rlen_reg};
        wr_addr   = wpos_reg;

        if (mode)
        begin
            if (phase_reg != PH_RUN)
            begin
                iss.err = ERR_IDLE_PULL;
            end
            else
            begin
                rec         = 1'b1;
                iss.is_data = 1'b1;
                case (kind_reg)
                    KIND_FILL:     iss.direct = f1_reg;
                    KIND_FILL2:    iss.direct = ridx_reg[0] ? f2_reg : f1_reg;
                    KIND_SEQ:      iss.direct = f1_reg + ridx_reg[7:0];
                    KIND_COPY:     iss.use_mem = 1'b1;
                    KIND_COPY_REV:
                    begin
                        iss.use_mem = 1'b1;
                        iss.rev     = 1'b1;
                    end
                    KIND_COPY_BWD: iss.use_mem = 1'b1;
                    default:       iss.direct = 8'h00;
                endcase
                ridx_next = idx_inc[10:0];
                if (idx_inc >= run_total)
                begin
                    phase_next   = PH_HEADER;
                    iss.finished = ending_reg;
                end
            end
        end
        else
        begin
            if (phase_reg == PH_RUN)
            begin
                iss.err = ERR_BUSY;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (in_byte == END_HEADER)
                        begin
                            iss.finished = 1'b1;
                        end
                        else if (in_byte[7:5] != KIND_EXT)
                        begin
                            kind_next  = in_byte[7:5];
                            rlen_next  = 11'(in_byte[4:0]) + 11'd1;
                            ridx_next  = '0;
                            phase_next = body_phase(in_byte[7:5]);
                        end
                        else
                        begin
                            kind_next = in_byte[4:2];
                            if (in_byte[4:2] != KIND_EXT)
                            begin
                                rlen_next  = {1'b0, in_byte[1:0], 8'h00};
                                phase_next = PH_EXTLEN;
                            end
                        end
                    end
                    PH_EXTLEN:
                    begin
                        rlen_next  = rlen_reg + 11'(in_byte) + 11'd1;
                        ridx_next  = '0;
                        phase_next = body_phase(kind_reg);
                    end
                    PH_OFS_HI:
                    begin
                        org_next   = {in_byte, 8'h00};
                        phase_next = PH_OFS_LO;
                    end
                    PH_OFS_LO:
                    begin
                        org_next   = mod_depth({org_reg[15:8], in_byte});
                        ridx_next  = '0;
                        phase_next = PH_RUN;
                    end
                    PH_PARAM1:
                    begin
                        f1_next    = in_byte;
                        ridx_next  = '0;
                        phase_next = (kind_reg == KIND_FILL2) ? PH_PARAM2 : PH_RUN;
                    end
                    PH_PARAM2:
                    begin
                        f2_next    = in_byte;
                        ridx_next  = '0;
                        phase_next = PH_RUN;
                    end
                    default:
                    begin
                        rec         = 1'b1;
                        iss.is_data = 1'b1;
                        iss.direct  = in_byte;
                        ridx_next   = idx_inc[10:0];
                        if (idx_inc >= {1'b0, rlen_reg})
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                endcase
                // A last mark either arms the end of a pending run or ends now
                if (last_byte && !iss.finished)
                begin
                    if (phase_next == PH_RUN)
                    begin
                        ending_next = 1'b1;
                    end
                    else
                    begin
                        iss.finished = 1'b1;
                    end
                end
            end
        end

        // Advance write position and saturating byte count
        if (rec)
        begin
            wpos_next = (wpos_reg == WPOS_LAST) ? '0 : wpos_reg + AW'(1);
            if (count_reg != 32'hFFFF_FFFF)
            begin
                count_next = count_reg + 32'd1;
            end
        end

        // Report the total and drop the stream state on finish
        if (iss.finished)
        begin
            iss.total   = count_next;
            phase_next  = PH_HEADER;
            kind_next   = '0;
            rlen_next   = '0;
            ridx_next   = '0;
            org_next    = '0;
            f1_next     = '0;
            f2_next     = '0;
            wpos_next   = '0;
            count_next  = '0;
            ending_next = 1'b0;
        end

        iss.has_result = iss.is_data || iss.finished || (iss.err != ERR_NONE);
    end

    // Parse state, updated on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            kind_reg   <= '0;
            rlen_reg   <= '0;
            ridx_reg   <= '0;
            org_reg    <= '0;
            f1_reg     <= '0;
            f2_reg     <= '0;
            wpos_reg   <= '0;
            count_reg  <= '0;
            ending_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            rlen_reg   <= rlen_next;
            ridx_reg   <= ridx_next;
            org_reg    <= org_next;
            f1_reg     <= f1_next;
            f2_reg     <= f2_next;
            wpos_reg   <= wpos_next;
            count_reg  <= count_next;
            ending_reg <= ending_next;
        end
    end

endmodule

FILE: hdl/lz_run_command_decompressor.sv
// Channel  Handshake               Payload
// input    in_valid / in_ready     mode, in_byte, last_byte
// output   out_valid / out_ready   out_byte, is_data, finished, total_length, error_code
//
// One beat per cycle sustained while out_ready is held high; a taken beat's result is
// registered in the read stage for the history read, then in the output register.
// Parse state updates at accept; the history write happens as the beat leaves the read stage.
// A copy byte that reads the entry being written in that cycle is forwarded.
// in_ready drops only when both the read stage and the output register are full.
// Reset clears the parse state; the history holds no reset value.
module lz_run_command_decompressor
    import lzrd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  in_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_data,
    output logic        finished,
    output logic [31:0] total_length,
    output logic [1:0]  error_code
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    lzrd_issue_t   iss;
    logic          accept;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_data;

    logic          s1_valid_reg;
    lzrd_issue_t   s1_reg;
    logic [AW-1:0] s1_waddr_reg;
    logic          s1_hit_reg;
    logic [7:0]    s1_fwd_reg;
    logic          s1_adv;
    logic [7:0]    mem_byte;
    logic [7:0]    s1_byte;
    logic          hit;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          is_data_reg;
    logic          finished_reg;
    logic [31:0]   total_reg;
    logic [1:0]    err_reg;

    // Handshake: the read stage drains into the output register
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    lzrd_parser #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (mode),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .iss       (iss),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    lzrd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (s1_adv && s1_reg.is_data),
        .wr_addr (s1_waddr_reg),
        .wr_data (s1_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Form the data byte from the history or the decoded value
    always_comb
    begin
        mem_byte = s1_hit_reg ? s1_fwd_reg : rd_data;
        if (!s1_reg.is_data)
        begin
            s1_byte = 8'h00;
        end
        else if (s1_reg.use_mem)
        begin
            s1_byte = s1_reg.rev ? bit_reverse8(mem_byte) : mem_byte;
        end
        else
        begin
            s1_byte = s1_reg.direct;
        end
    end

    // Forward the byte written this cycle when the new read hits it
    assign hit = rd_en && s1_adv && s1_reg.is_data && (rd_addr == s1_waddr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= iss.has_result;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= iss;
            s1_waddr_reg <= wr_addr;
            s1_hit_reg   <= hit;
            s1_fwd_reg   <= s1_byte;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_byte_reg <= s1_byte;
            is_data_reg  <= s1_reg.is_data;
            finished_reg <= s1_reg.finished;
            total_reg    <= s1_reg.total;
            err_reg      <= s1_reg.err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign is_data      = is_data_reg;
    assign finished     = finished_reg;
    assign total_length = total_reg;
    assign error_code   = err_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_status_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !finished) |-> (total_length == 32'd0))
        else $error("total reported on an unfinished result");

    a_error_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (error_code != ERR_NONE)) |-> (!is_data && !finished))
        else $error("error result carries data or finish");

    a_hit_only_on_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_hit_reg && s1_reg.is_data) |-> s1_reg.use_mem
        || $past(s1_adv))
        else $error("forward hit without a preceding write");
`endif

endmodule

FILE: tb/tb.sv
module tb
    import lzrd_pkg::*;
();

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_PULL = 1'b1;

    localparam int RANDOM_BEATS = 1300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SCRIPT_LEN   = 31;

    typedef enum logic [2:0]
    {
        P_HEAD, P_EXT_LEN, P_ORG_HI, P_ORG_LO, P_ARG_A, P_ARG_B, P_LIT, P_RUN
    } cmd_phase_t;

    typedef struct packed
    {
        logic [7:0]  data;
        logic        is_data;
        logic        fin;
        logic [31:0] total;
        logic [1:0]  err;
    } beat_result_t;

    typedef struct packed
    {
        logic         m;
        logic [7:0]   b;
        logic         l;
        logic         typed;
        beat_result_t want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        is_data;
    logic        finished;
    logic [31:0] total_length;
    logic [1:0]  error_code;

    // Decoder state as the block should hold it
    cmd_phase_t  cmd_phase = P_HEAD;
    logic [2:0]  cmd_kind = KIND_LITERAL;
    int          cmd_len = 0;
    int          cmd_pos = 0;
    logic [15:0] cmd_org = '0;
    logic [7:0]  fill_a = '0;
    logic [7:0]  fill_b = '0;
    logic [15:0] wr_pos = '0;
    logic [31:0] out_count = '0;
    bit          close_pending = 1'b0;
    logic [7:0]  hist [0:65535];
    int          hist_top = 0;

    // Plans for the command the generator is building
    int          plan_len = 1;
    logic [15:0] plan_org = '0;

    beat_result_t due_results [$];

    int send_idle_pct = 18;
    int take_stall_pct = 75;
    int misses = 0;
    int cycles = 0;
    int beats_sent = 0;
    int n_data = 0;
    int n_closed = 0;
    int n_errors = 0;

    // Opening beats: every command kind, extremes, and the misplaced-beat cases
    script_row_t script_rows [SCRIPT_LEN] = '{
        // pull straight after reset, then an empty stream
        '{MODE_PULL, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd0, ERR_IDLE_PULL}},
        '{MODE_BYTE, 8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 32'd0, ERR_NONE}},
        // two-byte fill, one pair, with a stray byte carrying a last mark
        '{MODE_BYTE, 8'h40, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'h12, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'h34, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'h56, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd0, ERR_BUSY}},
        '{MODE_PULL, 8'h00, 1'b0, 1'b1, '{8'h12, 1'b1, 1'b0, 32'd0, ERR_NONE}},
        '{MODE_PULL, 8'h00, 1'b0, 1'b1, '{8'h34, 1'b1, 1'b0, 32'd0, ERR_NONE}},
        // sequence from the top seed wraps to zero
        '{MODE_BYTE, 8'h61, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'hFF, 1'b0, 1'b0, '0},
        '{MODE_PULL, 8'h00, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 32'd0, ERR_NONE}},
        '{MODE_PULL, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd0, ERR_NONE}},
        // extended no-op header
        '{MODE_BYTE, 8'hFD, 1'b0, 1'b0, '0},
        // single byte fill
        '{MODE_BYTE, 8'h20, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'hA5, 1'b0, 1'b0, '0},
        '{MODE_PULL, 8'h00, 1'b0, 1'b1, '{8'hA5, 1'b1, 1'b0, 32'd0, ERR_NONE}},
        // forward copy whose offset byte is marked last: its pull closes the stream
        '{MODE_BYTE, 8'h80, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'h00, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'h01, 1'b1, 1'b0, '0},
        '{MODE_PULL, 8'h00, 1'b0, 1'b0, '0},
        // bit-reversed copy in the next stream
        '{MODE_BYTE, 8'hA0, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'h00, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'h00, 1'b0, 1'b0, '0},
        '{MODE_PULL, 8'h00, 1'b0, 1'b0, '0},
        // backward copy
        '{MODE_BYTE, 8'hC0, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'h00, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'h04, 1'b0, 1'b0, '0},
        '{MODE_PULL, 8'h00, 1'b0, 1'b0, '0},
        // extended literal of the longest length, cut short by a last mark
        '{MODE_BYTE, 8'hE3, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'hFF, 1'b0, 1'b0, '0},
        '{MODE_BYTE, 8'h00, 1'b1, 1'b0, '0}
    };

    lz_run_command_decompressor i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .in_byte      (in_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_data      (is_data),
        .finished     (finished),
        .total_length (total_length),
        .error_code   (error_code)
    );

    always #10 clk = ~clk;

    // Append one output byte to the history and the stream count
    function automatic void store_byte(input logic [7:0] d);
        hist[wr_pos] = d;
        if (int'(wr_pos) >= hist_top)
        begin
            hist_top = int'(wr_pos) + 1;
        end
        wr_pos = wr_pos + 16'd1;
        if (out_count != '1)
        begin
            out_count = out_count + 32'd1;
        end
    endfunction

    // Advance from the length to the command's parameters, or to its data for a literal
    function automatic void open_body();
        cmd_pos = 0;
        if (cmd_kind == KIND_LITERAL)
        begin
            cmd_phase = P_LIT;
        end
        else if (cmd_kind <= KIND_SEQ)
        begin
            cmd_phase = P_ARG_A;
        end
        else
        begin
            cmd_phase = P_ORG_HI;
        end
    endfunction

    // Apply one accepted beat; return 1 when it owes a result
    function automatic bit decode_beat(input logic m, input logic [7:0] b, input logic l,
                                       output beat_result_t r);
        bit emit;
        bit fin;
        logic [7:0] d;
        int span;
        r = '0;
        emit = 1'b0;
        fin = 1'b0;
        d = 8'h00;
        if (m == MODE_PULL)
        begin
            if (cmd_phase != P_RUN)
            begin
                r.err = ERR_IDLE_PULL;
                return 1'b1;
            end
            case (cmd_kind)
                KIND_FILL:     d = fill_a;
                KIND_FILL2:    d = cmd_pos[0] ? fill_b : fill_a;
                KIND_SEQ:      d = fill_a + 8'(cmd_pos);
                KIND_COPY:     d = hist[cmd_org + 16'(cmd_pos)];
                KIND_COPY_REV: d = {<<{hist[cmd_org + 16'(cmd_pos)]}};
                KIND_COPY_BWD: d = hist[cmd_org - 16'(cmd_pos)];
                default:       d = 8'h00;
            endcase
            store_byte(d);
            emit = 1'b1;
            cmd_pos++;
            span = (cmd_kind == KIND_FILL2) ? 2 * cmd_len : cmd_len;
            if (cmd_pos >= span)
            begin
                cmd_phase = P_HEAD;
                fin = close_pending;
            end
        end
        else
        begin
            if (cmd_phase == P_RUN)
            begin
                r.err = ERR_BUSY;
                return 1'b1;
            end
            case (cmd_phase)
                P_HEAD:
                begin
                    if (b == END_HEADER)
                    begin
                        fin = 1'b1;
                    end
                    else if (b[7:5] != KIND_EXT)
                    begin
                        cmd_kind = b[7:5];
                        cmd_len = int'(b[4:0]) + 1;
                        open_body();
                    end
                    else
                    begin
                        cmd_kind = b[4:2];
                        if (cmd_kind != KIND_EXT)
                        begin
                            cmd_len = int'(b[1:0]) * 256;
                            cmd_phase = P_EXT_LEN;
                        end
                    end
                end
                P_EXT_LEN:
                begin
                    cmd_len = cmd_len + int'(b) + 1;
                    open_body();
                end
                P_ORG_HI:
                begin
                    cmd_org = {b, 8'h00};
                    cmd_phase = P_ORG_LO;
                end
                P_ORG_LO:
                begin
                    cmd_org = cmd_org | {8'h00, b};
                    cmd_pos = 0;
                    cmd_phase = P_RUN;
                end
                P_ARG_A:
                begin
                    fill_a = b;
                    cmd_pos = 0;
                    cmd_phase = (cmd_kind == KIND_FILL2) ? P_ARG_B : P_RUN;
                end
                P_ARG_B:
                begin
                    fill_b = b;
                    cmd_pos = 0;
                    cmd_phase = P_RUN;
                end
                default:
                begin
                    d = b;
                    store_byte(d);
                    emit = 1'b1;
                    cmd_pos++;
                    if (cmd_pos >= cmd_len)
                    begin
                        cmd_phase = P_HEAD;
                    end
                end
            endcase
            // a last mark either closes at once or waits for the run to drain
            if (l && !fin)
            begin
                if (cmd_phase == P_RUN)
                begin
                    close_pending = 1'b1;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
        end
        if (emit)
        begin
            r.data = d;
            r.is_data = 1'b1;
        end
        if (fin)
        begin
            r.fin = 1'b1;
            r.total = out_count;
            // drop back to a fresh stream; history stays
            cmd_phase = P_HEAD;
            cmd_kind = KIND_LITERAL;
            cmd_len = 0;
            cmd_pos = 0;
            cmd_org = '0;
            fill_a = '0;
            fill_b = '0;
            wr_pos = '0;
            out_count = '0;
            close_pending = 1'b0;
        end
        return emit || fin;
    endfunction

    // Choose the next beat from the current decode state
    function automatic void pick_beat(output logic m, output logic [7:0] b, output logic l,
                                      output bit junk);
        int unsigned roll;
        int span;
        logic [2:0] k;
        logic [9:0] lm1;
        m = MODE_BYTE;
        b = 8'($urandom);
        l = 1'b0;
        junk = 1'b0;
        roll = $urandom_range(99);
        // misplaced beats: a byte during a run, a pull outside one
        if (roll < 4)
        begin
            junk = 1'b1;
            m = (cmd_phase == P_RUN) ? MODE_BYTE : MODE_PULL;
            l = 1'($urandom);
            return;
        end
        case (cmd_phase)
            P_RUN:
            begin
                m = MODE_PULL;
                l = 1'($urandom);
            end
            P_HEAD:
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                begin
                    b = END_HEADER;
                end
                else if (roll < 7)
                begin
                    b = {KIND_EXT, KIND_EXT, 2'($urandom_range(2))};
                end
                else
                begin
                    k = 3'($urandom_range(6));
                    if (k >= KIND_COPY && hist_top == 0)
                    begin
                        k = 3'($urandom_range(3));
                    end
                    span = ($urandom_range(99) < 4) ? $urandom_range(1024, 1)
                                                    : $urandom_range(40, 1);
                    // keep every copy read inside written history
                    if ((k == KIND_COPY_BWD || (k >= KIND_COPY && wr_pos == 0))
                        && span > hist_top)
                    begin
                        span = hist_top;
                    end
                    plan_len = span;
                    lm1 = 10'(span - 1);
                    if (span <= 32 && $urandom_range(3) != 0)
                    begin
                        b = {k, lm1[4:0]};
                    end
                    else
                    begin
                        b = {KIND_EXT, k, lm1[9:8]};
                    end
                end
                l = ($urandom_range(99) < 2);
            end
            P_EXT_LEN:
            begin
                lm1 = 10'(plan_len - 1);
                b = lm1[7:0];
                l = ($urandom_range(99) < 2);
            end
            P_ORG_HI:
            begin
                if (cmd_kind == KIND_COPY_BWD)
                begin
                    plan_org = 16'($urandom_range(hist_top - 1, cmd_len - 1));
                end
                else if (wr_pos != 0 && (hist_top < cmd_len || $urandom_range(1) == 0))
                begin
                    // trail the write pointer so the copy reads its own output
                    plan_org = wr_pos - 16'($urandom_range((wr_pos < 4) ? wr_pos : 4, 1));
                end
                else
                begin
                    plan_org = 16'($urandom_range(hist_top - cmd_len, 0));
                end
                b = plan_org[15:8];
                l = ($urandom_range(99) < 2);
            end
            P_ORG_LO:
            begin
                b = plan_org[7:0];
                l = ($urandom_range(99) < 10);
            end
            P_ARG_A:
            begin
                l = ($urandom_range(99) < ((cmd_kind == KIND_FILL2) ? 2 : 10));
            end
            P_ARG_B:
            begin
                l = ($urandom_range(99) < 10);
            end
            default:
            begin
                l = ($urandom_range(99) < 2);
            end
        endcase
    endfunction

    // Offer one beat, hold it until taken, then predict its result
    task automatic send_beat(input logic m, input logic [7:0] b, input logic l,
                             input logic typed, input beat_result_t want);
        beat_result_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        in_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (decode_beat(m, b, l, got))
        begin
            due_results.push_back(typed ? want : got);
        end
        beats_sent++;
    endtask

    task automatic flag(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: bad %s, got %0h, want %0h", $time, field, got, want);
        misses++;
    endtask

    // Throttle the result side
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= take_stall_pct);
    end

    // Compare each result beat with the oldest owed one
    always @(posedge clk)
    begin : watch_results
        beat_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (is_data)
            begin
                n_data++;
            end
            if (finished)
            begin
                n_closed++;
            end
            if (error_code != ERR_NONE)
            begin
                n_errors++;
            end
            if (due_results.size() == 0)
            begin
                flag("result with none owed", {24'h0, out_byte}, 32'h0);
            end
            else
            begin
                want = due_results.pop_front();
                if (out_byte !== want.data)
                begin
                    flag("out_byte", {24'h0, out_byte}, {24'h0, want.data});
                end
                if (is_data !== want.is_data)
                begin
                    flag("is_data", {31'h0, is_data}, {31'h0, want.is_data});
                end
                if (finished !== want.fin)
                begin
                    flag("finished", {31'h0, finished}, {31'h0, want.fin});
                end
                if (total_length !== want.total)
                begin
                    flag("total_length", total_length, want.total);
                end
                if (error_code !== want.err)
                begin
                    flag("error_code", {30'h0, error_code}, {30'h0, want.err});
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("lz_run_command_decompressor: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic m;
        logic [7:0] b;
        logic l;
        bit junk;
        int work_done;
        int stage;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        foreach (script_rows[i])
        begin
            send_beat(script_rows[i].m, script_rows[i].b, script_rows[i].l,
                      script_rows[i].typed, script_rows[i].want);
        end

        // random commands, switching the idle pattern in thirds
        work_done = 0;
        stage = 0;
        while (work_done < RANDOM_BEATS)
        begin
            if ((stage == 0 && work_done >= RANDOM_BEATS / 3)
                || (stage == 1 && work_done >= 2 * RANDOM_BEATS / 3))
            begin
                // hold off until every owed result has drained
                in_valid <= 1'b0;
                @(posedge clk);
                while (due_results.size() != 0)
                begin
                    @(posedge clk);
                end
                stage++;
                send_idle_pct = (stage == 1) ? 75 : 0;
                take_stall_pct = (stage == 1) ? 18 : 0;
            end
            pick_beat(m, b, l, junk);
            send_beat(m, b, l, 1'b0, '0);
            if (!junk)
            begin
                work_done++;
            end
        end
        in_valid <= 1'b0;

        // drain, then allow the pipeline depth for strays
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("sent %0d beats; saw %0d data bytes, %0d stream ends, %0d error beats",
                 beats_sent, n_data, n_closed, n_errors);
        $display("history high mark %0d, %0d field mismatches", hist_top, misses);
        if (misses == 0)
        begin
            $display("lz_run_command_decompressor: match");
        end
        else
        begin
            $display("lz_run_command_decompressor: mismatch");
        end
        $finish;
    end

endmodule
